>>> sv/csq_pkg.sv
// Shared types and codes for the cursor sequence store.
`timescale 1ns / 1ps

package csq_pkg;

    // request kinds, carried in s_tuser
    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_ADVANCE = 3'd1;
    localparam logic [2:0] REQ_INSERT  = 3'd2;
    localparam logic [2:0] REQ_ATTACH  = 3'd3;
    localparam logic [2:0] REQ_REMOVE  = 3'd4;

    // result status codes
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_NOCUR = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2
    } cell_cmd_t;

    // row control: load_top overwrites cell 0 with the push data, rest follow cmd
    typedef struct packed {
        cell_cmd_t cmd;
        logic      load_top;
    } stack_ctl_t;

endpackage

>>> sv/cursor_sequence_store.sv
// Flow: advance, insert with a current entry or into a full store, attach, remove
// and unknown kinds go from the input transfer straight to the response state; start
// and insert without a current entry first drain, one entry moved per cycle between rows.
// Requests are taken only in idle; the response state waits for a free output register.
// Reset: synchronous, active low; clears count, cursor, FSM and output valid.
// Entry cells are not cleared; only counted entries are ever read.
`timescale 1ns / 1ps

module cursor_sequence_store #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IN_W     = ((WORD_BITS + 7) / 8) * 8,
    localparam int OUT_RAW  = 2 + 2 * CNT_W + 1 + WORD_BITS,
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // entry_value, zero padded
    input  logic [2:0]       s_tuser,   // req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    // status, entry_count, cursor_pos, has_current, current_value, zero padded
    output logic [OUT_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_RESP  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       cur_reg, cur_next;
    logic [1:0]             status_reg, status_next;
    logic                   pend_reg, pend_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;

    csq_pkg::stack_ctl_t    lctl, rctl;
    logic [WORD_BITS-1:0]   l_top, r_top, r_push;
    logic [WORD_BITS-1:0]   s_word;
    logic                   has_cur, full;
    logic [OUT_RAW-1:0]     out_raw;

    // left row holds entries before the cursor, right row the cursor onwards
    csq_stack #(.DEPTH(DEPTH), .W(WORD_BITS)) u_left (
        .aclk      (aclk),
        .ctl       (lctl),
        .push_data (r_top),
        .top_data  (l_top)
    );

    csq_stack #(.DEPTH(DEPTH), .W(WORD_BITS)) u_right (
        .aclk      (aclk),
        .ctl       (rctl),
        .push_data (r_push),
        .top_data  (r_top)
    );

    assign s_word  = s_tdata[WORD_BITS-1:0];
    assign has_cur = (cur_reg != cnt_reg);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign out_raw = {has_cur ? r_top : {WORD_BITS{1'b0}}, has_cur, cur_reg, cnt_reg,
                      status_reg};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cur_next     = cur_reg;
        status_next  = status_reg;
        pend_next    = pend_reg;
        word_next    = word_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        lctl         = '{cmd: csq_pkg::CELL_HOLD, load_top: 1'b0};
        rctl         = '{cmd: csq_pkg::CELL_HOLD, load_top: 1'b0};
        r_push       = s_word;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    status_next = csq_pkg::STS_DONE;
                    state_next  = ST_RESP;
                    case (s_tuser)
                        csq_pkg::REQ_START: begin
                            pend_next  = 1'b0;
                            state_next = ST_DRAIN;
                        end
                        csq_pkg::REQ_ADVANCE: begin
                            if (has_cur) begin
                                lctl.cmd = csq_pkg::CELL_PUSH;
                                rctl.cmd = csq_pkg::CELL_POP;
                                cur_next = cur_reg + CNT_W'(1);
                            end else begin
                                status_next = csq_pkg::STS_NOCUR;
                            end
                        end
                        csq_pkg::REQ_INSERT: begin
                            if (full) begin
                                status_next = csq_pkg::STS_FULL;
                            end else if (has_cur) begin
                                rctl.cmd = csq_pkg::CELL_PUSH;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end else begin
                                // front insert: pull everything right first
                                word_next  = s_word;
                                pend_next  = 1'b1;
                                state_next = ST_DRAIN;
                            end
                        end
                        csq_pkg::REQ_ATTACH: begin
                            if (full) begin
                                status_next = csq_pkg::STS_FULL;
                            end else if (has_cur) begin
                                // current moves left, new word replaces it on top
                                lctl.cmd      = csq_pkg::CELL_PUSH;
                                rctl.load_top = 1'b1;
                                cur_next      = cur_reg + CNT_W'(1);
                                cnt_next      = cnt_reg + CNT_W'(1);
                            end else begin
                                rctl.cmd = csq_pkg::CELL_PUSH;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        csq_pkg::REQ_REMOVE: begin
                            if (has_cur) begin
                                rctl.cmd = csq_pkg::CELL_POP;
                                cnt_next = cnt_reg - CNT_W'(1);
                            end else begin
                                status_next = csq_pkg::STS_NOCUR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (cur_reg != '0) begin
                    lctl.cmd = csq_pkg::CELL_POP;
                    rctl.cmd = csq_pkg::CELL_PUSH;
                    r_push   = l_top;
                    cur_next = cur_reg - CNT_W'(1);
                end else begin
                    if (pend_reg) begin
                        rctl.cmd = csq_pkg::CELL_PUSH;
                        r_push   = word_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'(out_raw);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            cur_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        word_reg   <= word_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> sv/csq_cell.sv
// One storage cell of a stack row: holds a word, or takes either neighbour's.
`timescale 1ns / 1ps

module csq_cell #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  csq_pkg::cell_cmd_t  cmd,
    input  logic [W-1:0]        prev_data,
    input  logic [W-1:0]        next_data,
    output logic [W-1:0]        data_q
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb begin
        case (cmd)
            csq_pkg::CELL_HOLD: data_next = data_reg;
            csq_pkg::CELL_PUSH: data_next = prev_data;
            csq_pkg::CELL_POP:  data_next = next_data;
            default:            data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

>>> sv/csq_stack.sv
// Row of cells forming a shift stack; cell 0 is the top.
`timescale 1ns / 1ps

module csq_stack #(
    parameter int DEPTH = 64,
    parameter int W     = 32
) (
    input  logic                aclk,
    input  csq_pkg::stack_ctl_t ctl,
    input  logic [W-1:0]        push_data,
    output logic [W-1:0]        top_data
);

    logic [W-1:0] cell_q [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            csq_pkg::cell_cmd_t cell_cmd;
            logic [W-1:0]       prev_d;
            logic [W-1:0]       next_d;

            if (i == 0) begin : g_top
                assign cell_cmd = ctl.load_top ? csq_pkg::CELL_PUSH : ctl.cmd;
                assign prev_d   = push_data;
            end else begin : g_body
                assign cell_cmd = ctl.cmd;
                assign prev_d   = cell_q[i-1];
            end

            // bottom cell refills with stale data on a pop; never counted
            if (i == DEPTH - 1) begin : g_end
                assign next_d = cell_q[i];
            end else begin : g_link
                assign next_d = cell_q[i+1];
            end

            csq_cell #(.W(W)) u_cell (
                .aclk      (aclk),
                .cmd       (cell_cmd),
                .prev_data (prev_d),
                .next_data (next_d),
                .data_q    (cell_q[i])
            );
        end
    endgenerate

    assign top_data = cell_q[0];

endmodule

>>> sv/csq_checker.sv
// Port-level checks on the cursor sequence store, bound to the top level.
`timescale 1ns / 1ps

module csq_checker #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int OUT_RAW  = 2 + 2 * CNT_W + 1 + WORD_BITS,
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    localparam int CNT_LO = 2;
    localparam int CUR_LO = CNT_LO + CNT_W;
    localparam int HAS_AT = CUR_LO + CNT_W;
    localparam int VAL_LO = HAS_AT + 1;

    logic [CNT_W-1:0]     f_cnt;
    logic [CNT_W-1:0]     f_cur;
    logic                 f_has;
    logic [WORD_BITS-1:0] f_val;
    logic                 in_xfer;

    assign f_cnt   = m_tdata[CUR_LO-1:CNT_LO];
    assign f_cur   = m_tdata[HAS_AT-1:CUR_LO];
    assign f_has   = m_tdata[HAS_AT];
    assign f_val   = m_tdata[VAL_LO+WORD_BITS-1:VAL_LO];
    assign in_xfer = s_tvalid && s_tready;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (f_cur <= f_cnt) && (f_cnt <= CNT_W'(DEPTH)))
        else $error("cursor or count out of range");

    a_has: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (f_has == (f_cur != f_cnt)))
        else $error("has_current disagrees with cursor");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !f_has |-> (f_val == '0))
        else $error("value shown without current entry");

    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("request taken while previous still in work");

endmodule

bind cursor_sequence_store csq_checker #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
) u_csq_checker (.*);
